/* src/complex_arith_unit_macros.svh */
// Assertion macros for the complex arithmetic unit.
// Included by the top level only; no other dependencies.
`ifndef COMPLEX_ARITH_UNIT_MACROS_SVH
`define COMPLEX_ARITH_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CAU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define CAU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/cau_pkg.sv */
// Shared types and constants of the complex arithmetic unit.
// No dependencies.
package cau_pkg;

  localparam int DATA_W = 16;
  localparam int NUM_W  = 33;  // sum of two 16x16 products
  localparam int PROD_W = 32;
  localparam int DEN_W  = 32;
  localparam int QB     = 17;  // quotient bits kept before saturation
  localparam int REM_W  = 50;  // covers mag << 15 and den << QB
  localparam int RES_MAX = 32767;
  localparam int RES_MIN = -32768;

  typedef enum logic [1:0] {
    CMD_ADD = 2'd0,
    CMD_SUB = 2'd1,
    CMD_MUL = 2'd2,
    CMD_DIV = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DIVZ = 2'd1,
    ST_SAT  = 2'd2
  } status_e;

  // mul stage -> divide stage
  typedef struct packed {
    cmd_e                     cmd;
    logic signed [NUM_W-1:0]  num_re;
    logic signed [NUM_W-1:0]  num_im;
    logic [DEN_W-1:0]         den;
  } sum_t;

  // one stage of the divide chain
  typedef struct packed {
    logic              divz;
    logic              run_re;
    logic              run_im;
    logic              ovf_re;
    logic              ovf_im;
    logic              neg_re;
    logic              neg_im;
    logic [REM_W-1:0]  rem_re;
    logic [REM_W-1:0]  rem_im;
    logic [DEN_W-1:0]  den;
    logic [QB-1:0]     q_re;
    logic [QB-1:0]     q_im;
  } dstage_t;

  // divide stage -> saturation stage
  typedef struct packed {
    logic          divz;
    logic          ovf_re;
    logic          ovf_im;
    logic          neg_re;
    logic          neg_im;
    logic [QB-1:0] q_re;
    logic [QB-1:0] q_im;
  } quo_t;

endpackage

/* src/cau_mul.sv */
// Product and sum stages: six 16x16 products, then the numerators and divisor.
// Depends on cau_pkg.
module cau_mul import cau_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  output logic                     stall_o,
  input  logic [1:0]               cmd_i,
  input  logic signed [DATA_W-1:0] a_re_i,
  input  logic signed [DATA_W-1:0] a_im_i,
  input  logic signed [DATA_W-1:0] b_re_i,
  input  logic signed [DATA_W-1:0] b_im_i,
  output logic                     valid_o,
  input  logic                     stall_i,
  output sum_t                     sum_o
);

  logic                      v1_q, v2_q, stall1, stall2;
  cmd_e                      cmd1_q;
  logic signed [PROD_W-1:0]  rr_q, ii_q, ri_q, ir_q, bbr_q, bbi_q;
  logic signed [DATA_W:0]    sre_q, sim_q, sre_d, sim_d;
  sum_t                      sum_d, sum_q;

  assign stall2  = v2_q & stall_i;
  assign stall1  = v1_q & stall2;
  assign stall_o = stall1;

  always_comb begin
    if (cmd_e'(cmd_i) == CMD_SUB) begin
      sre_d = $signed({a_re_i[DATA_W-1], a_re_i}) - $signed({b_re_i[DATA_W-1], b_re_i});
      sim_d = $signed({a_im_i[DATA_W-1], a_im_i}) - $signed({b_im_i[DATA_W-1], b_im_i});
    end else begin
      sre_d = $signed({a_re_i[DATA_W-1], a_re_i}) + $signed({b_re_i[DATA_W-1], b_re_i});
      sim_d = $signed({a_im_i[DATA_W-1], a_im_i}) + $signed({b_im_i[DATA_W-1], b_im_i});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (!stall1) v1_q <= valid_i;
      if (!stall2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall1) begin
      cmd1_q <= cmd_e'(cmd_i);
      rr_q   <= PROD_W'(a_re_i * b_re_i);
      ii_q   <= PROD_W'(a_im_i * b_im_i);
      ri_q   <= PROD_W'(a_re_i * b_im_i);
      ir_q   <= PROD_W'(a_im_i * b_re_i);
      bbr_q  <= PROD_W'(b_re_i * b_re_i);
      bbi_q  <= PROD_W'(b_im_i * b_im_i);
      sre_q  <= sre_d;
      sim_q  <= sim_d;
    end
  end

  always_comb begin
    sum_d.cmd = cmd1_q;
    sum_d.den = $unsigned(bbr_q) + $unsigned(bbi_q);
    unique case (cmd1_q)
      CMD_ADD, CMD_SUB: begin
        sum_d.num_re = NUM_W'(sre_q);
        sum_d.num_im = NUM_W'(sim_q);
      end
      CMD_MUL: begin
        sum_d.num_re = NUM_W'(rr_q) - NUM_W'(ii_q);
        sum_d.num_im = NUM_W'(ri_q) + NUM_W'(ir_q);
      end
      CMD_DIV: begin
        sum_d.num_re = NUM_W'(rr_q) + NUM_W'(ii_q);
        sum_d.num_im = NUM_W'(ir_q) - NUM_W'(ri_q);
      end
      default: begin
        sum_d.num_re = '0;
        sum_d.num_im = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (!stall2) sum_q <= sum_d;
  end

  assign valid_o = v2_q;
  assign sum_o   = sum_q;

endmodule

/* src/cau_div.sv */
// Magnitude, rescale and restoring-divide chain (one quotient bit per stage).
// Depends on cau_pkg.
module cau_div import cau_pkg::*; #(
  parameter int FRAC_BITS = 8
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  output logic stall_o,
  input  sum_t sum_i,
  output logic valid_o,
  input  logic stall_i,
  output quo_t quo_o
);

  logic               va_q, stall_a;
  logic               isdiv_q, ismul_q, divz_q, neg_re_q, neg_im_q;
  logic [NUM_W-1:0]   mag_re_q, mag_im_q;
  logic [DEN_W-1:0]   den_q;
  logic [QB:0]        v_q;
  logic [QB+1:0]      hold;
  dstage_t            st_q [QB+1];
  dstage_t            init_d;
  logic [REM_W-1:0]   n_re, n_im, dlim;
  logic [NUM_W-1:0]   qm_re, qm_im;

  assign hold[QB+1] = stall_i;
  for (genvar j = 0; j <= QB; j++) begin : g_hold
    assign hold[j] = v_q[j] & hold[j+1];
  end
  assign stall_a = va_q & hold[0];
  assign stall_o = stall_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      v_q  <= '0;
    end else begin
      if (!stall_a) va_q <= valid_i;
      if (!hold[0]) v_q[0] <= va_q;
      for (int j = 1; j <= QB; j++) begin
        if (!hold[j]) v_q[j] <= v_q[j-1];
      end
    end
  end

  // magnitudes and flags
  always_ff @(posedge clk_i) begin
    if (!stall_a) begin
      isdiv_q  <= (sum_i.cmd == CMD_DIV);
      ismul_q  <= (sum_i.cmd == CMD_MUL);
      divz_q   <= (sum_i.cmd == CMD_DIV) && (sum_i.den == '0);
      neg_re_q <= sum_i.num_re[NUM_W-1];
      neg_im_q <= sum_i.num_im[NUM_W-1];
      mag_re_q <= sum_i.num_re[NUM_W-1] ? NUM_W'(-sum_i.num_re) : NUM_W'(sum_i.num_re);
      mag_im_q <= sum_i.num_im[NUM_W-1] ? NUM_W'(-sum_i.num_im) : NUM_W'(sum_i.num_im);
      den_q    <= sum_i.den;
    end
  end

  // rescale, range check, chain entry
  always_comb begin
    n_re  = REM_W'(mag_re_q) << FRAC_BITS;
    n_im  = REM_W'(mag_im_q) << FRAC_BITS;
    dlim  = REM_W'(den_q) << QB;
    qm_re = ismul_q ? (mag_re_q >> FRAC_BITS) : mag_re_q;
    qm_im = ismul_q ? (mag_im_q >> FRAC_BITS) : mag_im_q;
    init_d.divz   = divz_q;
    init_d.neg_re = neg_re_q;
    init_d.neg_im = neg_im_q;
    init_d.den    = den_q;
    if (isdiv_q) begin
      init_d.ovf_re = (n_re >= dlim);
      init_d.ovf_im = (n_im >= dlim);
      init_d.rem_re = n_re;
      init_d.rem_im = n_im;
      init_d.q_re   = '0;
      init_d.q_im   = '0;
    end else begin
      init_d.ovf_re = |qm_re[NUM_W-1:QB];
      init_d.ovf_im = |qm_im[NUM_W-1:QB];
      init_d.rem_re = '0;
      init_d.rem_im = '0;
      init_d.q_re   = qm_re[QB-1:0];
      init_d.q_im   = qm_im[QB-1:0];
    end
    init_d.run_re = isdiv_q & ~divz_q & ~init_d.ovf_re;
    init_d.run_im = isdiv_q & ~divz_q & ~init_d.ovf_im;
  end

  always_ff @(posedge clk_i) begin
    if (!hold[0]) st_q[0] <= init_d;
  end

  // one quotient bit per stage, MSB first
  for (genvar i = 0; i < QB; i++) begin : g_it
    localparam int K = QB - 1 - i;
    dstage_t          nxt;
    logic [REM_W-1:0] dsh;

    always_comb begin
      dsh = REM_W'(st_q[i].den) << K;
      nxt = st_q[i];
      if (st_q[i].run_re && (st_q[i].rem_re >= dsh)) begin
        nxt.rem_re  = st_q[i].rem_re - dsh;
        nxt.q_re[K] = 1'b1;
      end
      if (st_q[i].run_im && (st_q[i].rem_im >= dsh)) begin
        nxt.rem_im  = st_q[i].rem_im - dsh;
        nxt.q_im[K] = 1'b1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (!hold[i+1]) st_q[i+1] <= nxt;
    end
  end

  assign valid_o     = v_q[QB];
  assign quo_o.divz   = st_q[QB].divz;
  assign quo_o.ovf_re = st_q[QB].ovf_re;
  assign quo_o.ovf_im = st_q[QB].ovf_im;
  assign quo_o.neg_re = st_q[QB].neg_re;
  assign quo_o.neg_im = st_q[QB].neg_im;
  assign quo_o.q_re   = st_q[QB].q_re;
  assign quo_o.q_im   = st_q[QB].q_im;

endmodule

/* src/cau_sat.sv */
// Output stage: sign restore, saturation, status, output register.
// Depends on cau_pkg.
module cau_sat import cau_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              stall_o,
  input  quo_t              quo_i,
  output logic              valid_o,
  input  logic              stall_i,
  output logic [DATA_W-1:0] res_re_o,
  output logic [DATA_W-1:0] res_im_o,
  output status_e           status_o
);

  logic              vo_q;
  logic [DATA_W-1:0] re_q, im_q;
  status_e           st_q, st_d;
  logic [DATA_W:0]   cre, cim;

  function automatic logic [DATA_W:0] clamp(logic neg, logic ovf, logic [QB-1:0] q);
    logic signed [QB:0] s;
    logic [DATA_W:0]    r;
    s = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
    if (ovf)                            r = {1'b1, neg ? 16'h8000 : 16'h7fff};
    else if (s > (QB+1)'(RES_MAX))      r = {1'b1, 16'h7fff};
    else if (s < (QB+1)'(RES_MIN))      r = {1'b1, 16'h8000};
    else                                r = {1'b0, s[DATA_W-1:0]};
    return r;
  endfunction

  assign stall_o = vo_q & stall_i;

  always_comb begin
    cre = clamp(quo_i.neg_re, quo_i.ovf_re, quo_i.q_re);
    cim = clamp(quo_i.neg_im, quo_i.ovf_im, quo_i.q_im);
    if (quo_i.divz)                    st_d = ST_DIVZ;
    else if (cre[DATA_W] | cim[DATA_W]) st_d = ST_SAT;
    else                               st_d = ST_OK;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vo_q <= 1'b0;
    else if (!stall_o) vo_q <= valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (!stall_o) begin
      re_q <= quo_i.divz ? '0 : cre[DATA_W-1:0];
      im_q <= quo_i.divz ? '0 : cim[DATA_W-1:0];
      st_q <= st_d;
    end
  end

  assign valid_o  = vo_q;
  assign res_re_o = re_q;
  assign res_im_o = im_q;
  assign status_o = st_q;

endmodule

/* src/complex_arith_unit.sv */
// Channel | direction | handshake               | beat
// in      | input     | in_valid_i / in_stall_o  | cmd, a_re, a_im, b_re, b_im
// out     | output    | out_valid_o / out_stall_i| res_re, res_im, status
//
// Fully pipelined: one beat per cycle while the output is not stalled; the path from input to output
// is 2 product/sum stages, 2 setup stages, 17 restoring-divide stages and 1 output stage.
// The divide chain, one quotient bit per stage, sets the depth; every command
// takes the same path so order is kept.
// Reset (rst_ni, async, low) clears only the valid bits; data registers are not reset.
// Stalls propagate per stage: an empty stage keeps accepting, so bubbles collapse.
`include "complex_arith_unit_macros.svh"
module complex_arith_unit import cau_pkg::*; #(
  parameter int FRAC_BITS = 8
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [1:0]               cmd_i,
  input  logic signed [DATA_W-1:0] a_re_i,
  input  logic signed [DATA_W-1:0] a_im_i,
  input  logic signed [DATA_W-1:0] b_re_i,
  input  logic signed [DATA_W-1:0] b_im_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [DATA_W-1:0] res_re_o,
  output logic signed [DATA_W-1:0] res_im_o,
  output logic [1:0]               status_o
);

  // stage boundaries
  logic    mul_valid, mul_stall, div_valid, div_stall;
  sum_t    sum;
  quo_t    quo;
  status_e status;
  logic [DATA_W-1:0] res_re, res_im;

  // products and sums (also add/sub)
  cau_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .stall_o (in_stall_o),
    .cmd_i   (cmd_i),
    .a_re_i  (a_re_i),
    .a_im_i  (a_im_i),
    .b_re_i  (b_re_i),
    .b_im_i  (b_im_i),
    .valid_o (mul_valid),
    .stall_i (mul_stall),
    .sum_o   (sum)
  );

  // magnitude, rescale, divide chain (pass-through for other commands)
  cau_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (mul_valid),
    .stall_o (mul_stall),
    .sum_i   (sum),
    .valid_o (div_valid),
    .stall_i (div_stall),
    .quo_o   (quo)
  );

  // sign, saturation, status; holds the output register
  cau_sat u_sat (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (div_valid),
    .stall_o  (div_stall),
    .quo_i    (quo),
    .valid_o  (out_valid_o),
    .stall_i  (out_stall_i),
    .res_re_o (res_re),
    .res_im_o (res_im),
    .status_o (status)
  );

  assign res_re_o = $signed(res_re);
  assign res_im_o = $signed(res_im);
  assign status_o = status;

  // input can only back up when the output side is stalled
  `CAU_ASSERT_NOW(a_stall_src, in_stall_o, out_stall_i, "input stalled without output stall")
  // zero divisor gives a zero result
  `CAU_ASSERT_NOW(a_divz_zero, out_valid_o && (status_o == ST_DIVZ),
                  (res_re_o == '0) && (res_im_o == '0), "nonzero result on divide by zero")
  // saturated status means a part sits on a rail
  `CAU_ASSERT_NOW(a_sat_rail, out_valid_o && (status_o == ST_SAT),
                  (res_re_o == 16'sh7fff) || (res_re_o == -16'sh8000) ||
                  (res_im_o == 16'sh7fff) || (res_im_o == -16'sh8000),
                  "saturation flagged with no part at a rail")
  // a stalled output beat stays valid
  `CAU_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o,
                   "output beat dropped while stalled")

endmodule
